[src/lef_pkg.sv]
`timescale 1ns / 1ps

package lef_pkg;

  // Line geometry
  localparam int MaxWidth = 2048;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int RowW     = 16;
  localparam int WidthW   = 12;
  localparam int CfgW     = 16;

  // Result queue; also bounds the results in flight
  localparam int FifoDepth = 8;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = FifoPtrW + 1;

  // Register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Reset values of the registers
  localparam logic [WidthW-1:0] ResetWidth  = WidthW'(640);
  localparam logic [RowW-1:0]   ResetHeight = RowW'(480);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // One window column: top, middle and bottom row
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } column_t;

  // Nine samples of one channel, column by column, center at index 4
  typedef logic [8:0][7:0] chan_win_t;

  // Row and frame marks carried along with a result
  typedef struct packed {
    logic emit;
    logic row_done;
    logic frame_done;
  } mark_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_done;
    logic       frame_done;
  } result_t;

endpackage

[src/lef_ram.sv]
`timescale 1ns / 1ps

module lef_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/lef_cell.sv]
`timescale 1ns / 1ps

module lef_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  lef_pkg::column_t  col_i,
  output lef_pkg::column_t  col_o
);

  lef_pkg::column_t col_q;

  // Take the neighbor's column on each pixel transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (en_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

[src/lef_lap.sv]
`timescale 1ns / 1ps

module lef_lap (
  input  logic               clk_i,
  input  logic               en_i,
  input  lef_pkg::chan_win_t win_i,
  output logic [7:0]         edge_o
);

  logic        [11:0] sum9;
  logic        [11:0] nine_c;
  logic signed [12:0] resp_d;
  logic signed [12:0] resp_q;

  // Nine times the center minus all nine samples
  always_comb begin
    sum9 = '0;
    for (int k = 0; k < 9; k++) begin
      sum9 = sum9 + 12'(win_i[k]);
    end
    nine_c = {1'b0, win_i[4], 3'b000} + 12'(win_i[4]);
    resp_d = $signed({1'b0, nine_c}) - $signed({1'b0, sum9});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      resp_q <= resp_d;
    end
  end

  // Clamp to 0..255
  always_comb begin
    if (resp_q[12] || (resp_q == 13'sd0)) begin
      edge_o = 8'd0;
    end else if (resp_q[11:0] >= 12'd255) begin
      edge_o = 8'hFF;
    end else begin
      edge_o = resp_q[7:0];
    end
  end

endmodule

[src/laplacian_edge_filter_rgb.sv]
`timescale 1ns / 1ps
// A result passes the pixel register, window cells, response register and queue, then is valid.
// Throughput: one pixel per cycle; in_ready_o drops only while 8 results are outstanding,
//   which the result queue at the output sets.
// Reset clears the frame position, the window cells, the result queue and sets the frame to
//   640 x 480. The line stores are not cleared; each entry is written before a result uses it.

module laplacian_edge_filter_rgb (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [lef_pkg::CfgW-1:0]  cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                pixel_red_i,
  input  logic [7:0]                pixel_green_i,
  input  logic [7:0]                pixel_blue_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [7:0]                edge_red_o,
  output logic [7:0]                edge_green_o,
  output logic [7:0]                edge_blue_o,
  output logic                      row_done_o,
  output logic                      frame_done_o
);

  localparam int ColW = lef_pkg::ColW;
  localparam int RowW = lef_pkg::RowW;

  // Configuration and frame position
  logic [lef_pkg::WidthW-1:0] width_q;
  logic [RowW-1:0]            height_q;
  logic [ColW-1:0]            col_q, col_d;
  logic [RowW-1:0]            row_q, row_d;
  logic [ColW-1:0]            last_col;
  logic [RowW-1:0]            last_row;

  logic          in_xfer, out_xfer;
  lef_pkg::pix_t px_in;
  lef_pkg::mark_t mark_in;

  // Pipeline registers
  logic            v1_q;
  lef_pkg::pix_t   px1_q;
  logic [ColW-1:0] col1_q;
  lef_pkg::mark_t  mark1_q, mark2_q, mark3_q;

  logic [2*$bits(lef_pkg::pix_t)-1:0] ram_rdata;
  lef_pkg::pix_t    top_px, mid_px;
  lef_pkg::column_t new_col;
  lef_pkg::column_t cell_col [3];

  lef_pkg::chan_win_t win_r, win_g, win_b;
  logic [7:0] edge_r, edge_g, edge_b;

  // Result queue and credit count
  lef_pkg::result_t               fifo_q [lef_pkg::FifoDepth];
  logic [lef_pkg::FifoPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [lef_pkg::FifoCntW-1:0]   cnt_q, occ_q;
  logic                           fifo_we;
  lef_pkg::result_t               fifo_wdata;

  assign in_ready_o = (occ_q < lef_pkg::FifoCntW'(lef_pkg::FifoDepth));
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_xfer   = out_valid_o && out_ready_i;

  assign px_in = '{red: pixel_red_i, green: pixel_green_i, blue: pixel_blue_i};

  // Effective last column and last row
  always_comb begin
    if (width_q < lef_pkg::WidthW'(3)) begin
      last_col = ColW'(2);
    end else if (width_q > lef_pkg::WidthW'(lef_pkg::MaxWidth)) begin
      last_col = ColW'(lef_pkg::MaxWidth - 1);
    end else begin
      last_col = ColW'(width_q - lef_pkg::WidthW'(1));
    end
    if (height_q < RowW'(3)) begin
      last_row = RowW'(2);
    end else begin
      last_row = height_q - RowW'(1);
    end
  end

  // Marks for the pixel now transferred
  always_comb begin
    mark_in.emit       = (col_q >= ColW'(2)) && (row_q >= RowW'(2));
    mark_in.row_done   = (col_q >= last_col);
    mark_in.frame_done = mark_in.row_done && (row_q >= last_row);
  end

  // Advance the frame position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_xfer) begin
      if (col_q >= last_col) begin
        col_d = '0;
        row_d = (row_q >= last_row) ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  // Registers and position; a register write restarts the frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lef_pkg::ResetWidth;
      height_q <= lef_pkg::ResetHeight;
      col_q    <= '0;
      row_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lef_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data_i[lef_pkg::WidthW-1:0];
        lef_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Hold the pixel while the line stores are read
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      px1_q  <= px_in;
      col1_q <= col_q;
    end
  end

  // Advance the valid and mark bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      mark1_q <= '0;
      mark2_q <= '0;
      mark3_q <= '0;
    end else begin
      v1_q    <= in_xfer;
      mark1_q <= in_xfer ? mark_in : '0;
      mark2_q <= v1_q ? mark1_q : '0;
      mark3_q <= mark2_q;
    end
  end

  // Both line stores in one memory: upper in the high half, middle in the low half
  lef_ram #(
    .Width(2 * $bits(lef_pkg::pix_t)),
    .Depth(lef_pkg::MaxWidth)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (v1_q),
    .waddr_i(col1_q),
    .wdata_i({mid_px, px1_q}),
    .re_i   (in_xfer),
    .raddr_i(col_q),
    .rdata_o(ram_rdata)
  );

  assign top_px  = ram_rdata[2*$bits(lef_pkg::pix_t)-1:$bits(lef_pkg::pix_t)];
  assign mid_px  = ram_rdata[$bits(lef_pkg::pix_t)-1:0];
  assign new_col = '{top: top_px, mid: mid_px, bot: px1_q};

  // Window cells: newest column enters cell 2 and moves toward cell 0
  lef_cell u_cell2 (
    .clk_i (clk_i), .rst_ni(rst_ni), .en_i(v1_q), .col_i(new_col), .col_o(cell_col[2])
  );
  lef_cell u_cell1 (
    .clk_i (clk_i), .rst_ni(rst_ni), .en_i(v1_q), .col_i(cell_col[2]), .col_o(cell_col[1])
  );
  lef_cell u_cell0 (
    .clk_i (clk_i), .rst_ni(rst_ni), .en_i(v1_q), .col_i(cell_col[1]), .col_o(cell_col[0])
  );

  // Split the window into channels
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_r[3*k]   = cell_col[k].top.red;
      win_r[3*k+1] = cell_col[k].mid.red;
      win_r[3*k+2] = cell_col[k].bot.red;
      win_g[3*k]   = cell_col[k].top.green;
      win_g[3*k+1] = cell_col[k].mid.green;
      win_g[3*k+2] = cell_col[k].bot.green;
      win_b[3*k]   = cell_col[k].top.blue;
      win_b[3*k+1] = cell_col[k].mid.blue;
      win_b[3*k+2] = cell_col[k].bot.blue;
    end
  end

  lef_lap u_lap_r (.clk_i(clk_i), .en_i(mark2_q.emit), .win_i(win_r), .edge_o(edge_r));
  lef_lap u_lap_g (.clk_i(clk_i), .en_i(mark2_q.emit), .win_i(win_g), .edge_o(edge_g));
  lef_lap u_lap_b (.clk_i(clk_i), .en_i(mark2_q.emit), .win_i(win_b), .edge_o(edge_b));

  assign fifo_we    = mark3_q.emit;
  assign fifo_wdata = '{red: edge_r, green: edge_g, blue: edge_b,
                        row_done: mark3_q.row_done, frame_done: mark3_q.frame_done};

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_q[wr_ptr_q] <= fifo_wdata;
    end
  end

  // Queue pointers, fill count and outstanding results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      occ_q    <= '0;
    end else begin
      if (fifo_we) begin
        wr_ptr_q <= wr_ptr_q + lef_pkg::FifoPtrW'(1);
      end
      if (out_xfer) begin
        rd_ptr_q <= rd_ptr_q + lef_pkg::FifoPtrW'(1);
      end
      cnt_q <= cnt_q + lef_pkg::FifoCntW'(fifo_we) - lef_pkg::FifoCntW'(out_xfer);
      occ_q <= occ_q + lef_pkg::FifoCntW'(in_xfer && mark_in.emit)
                     - lef_pkg::FifoCntW'(out_xfer);
    end
  end

  assign edge_red_o   = fifo_q[rd_ptr_q].red;
  assign edge_green_o = fifo_q[rd_ptr_q].green;
  assign edge_blue_o  = fifo_q[rd_ptr_q].blue;
  assign row_done_o   = fifo_q[rd_ptr_q].row_done;
  assign frame_done_o = fifo_q[rd_ptr_q].frame_done;

  // Outstanding results never exceed the queue depth
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= lef_pkg::FifoCntW'(lef_pkg::FifoDepth))
    else $error("outstanding results exceed queue depth");

  // Queued results are a subset of the outstanding ones
  a_cnt_le_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= occ_q)
    else $error("queue holds more than outstanding results");

  // A queue write never lands in a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_we |-> (cnt_q < lef_pkg::FifoCntW'(lef_pkg::FifoDepth)))
    else $error("result queue overflow");

  // An emitting transfer reaches the queue through mark1_q, mark2_q and mark3_q
  a_emit_reaches_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && mark_in.emit) |-> ##3 fifo_we)
    else $error("result lost in pipeline");

  // A frame mark always comes with a row mark
  a_frame_has_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_we |-> (!mark3_q.frame_done || mark3_q.row_done))
    else $error("frame mark without row mark");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CycleLimit   = 2_000_000;
  localparam int unsigned DrainCycles  = 12;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned WidePixels   = 200;
  localparam int unsigned RandomPixels = 1100;

  typedef enum int {PIX_NOISE, PIX_SMOOTH, PIX_RAILS} pix_style_e;

  // A pixel to send, with the filter output it must give when stated by hand
  typedef struct packed {
    lef_pkg::pix_t    px;
    logic             given;
    lef_pkg::result_t res;
  } step_t;

  localparam lef_pkg::pix_t    RingA  = '{8'd0, 8'd255, 8'd9};
  localparam lef_pkg::pix_t    CoreA  = '{8'd255, 8'd0, 8'd10};
  localparam lef_pkg::result_t EdgeA  = '{8'd255, 8'd0, 8'd8, 1'b1, 1'b1};
  localparam lef_pkg::pix_t    Dark   = '{8'd0, 8'd0, 8'd0};
  localparam lef_pkg::pix_t    CoreB  = '{8'd1, 8'd2, 8'd3};
  localparam lef_pkg::result_t EdgeB  = '{8'd8, 8'd16, 8'd24, 1'b1, 1'b1};
  localparam lef_pkg::result_t NoEdge = '0;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic                     cfg_index_i;
  logic [lef_pkg::CfgW-1:0] cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [7:0]               pixel_red_i;
  logic [7:0]               pixel_green_i;
  logic [7:0]               pixel_blue_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [7:0]               edge_red_o;
  logic [7:0]               edge_green_o;
  logic [7:0]               edge_blue_o;
  logic                     row_done_o;
  logic                     frame_done_o;

  // Two 3x3 frames back to back: bright center on a ring, then a faint dot on black
  step_t directed [18] = '{
    '{RingA, 1'b0, NoEdge}, '{RingA, 1'b0, NoEdge}, '{RingA, 1'b0, NoEdge},
    '{RingA, 1'b0, NoEdge}, '{CoreA, 1'b0, NoEdge}, '{RingA, 1'b0, NoEdge},
    '{RingA, 1'b0, NoEdge}, '{RingA, 1'b0, NoEdge}, '{RingA, 1'b1, EdgeA},
    '{Dark,  1'b0, NoEdge}, '{Dark,  1'b0, NoEdge}, '{Dark,  1'b0, NoEdge},
    '{Dark,  1'b0, NoEdge}, '{CoreB, 1'b0, NoEdge}, '{Dark,  1'b0, NoEdge},
    '{Dark,  1'b0, NoEdge}, '{Dark,  1'b0, NoEdge}, '{Dark,  1'b1, EdgeB}
  };

  // Filter state mirror
  lef_pkg::pix_t              upper_line [lef_pkg::MaxWidth];
  lef_pkg::pix_t              middle_line [lef_pkg::MaxWidth];
  lef_pkg::column_t           left_col;
  lef_pkg::column_t           center_col;
  int unsigned                col_pos;
  int unsigned                row_pos;
  logic [lef_pkg::WidthW-1:0] width_reg;
  logic [lef_pkg::RowW-1:0]   height_reg;

  step_t            stated_results [$];
  lef_pkg::result_t pending_edges [$];
  int unsigned      errors;
  int unsigned      cycle_count;
  bit               quiet_send;
  bit               quiet_recv;
  bit               backpressure_req;

  laplacian_edge_filter_rgb i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .pixel_red_i,
    .pixel_green_i,
    .pixel_blue_i,
    .out_valid_o,
    .out_ready_i,
    .edge_red_o,
    .edge_green_o,
    .edge_blue_o,
    .row_done_o,
    .frame_done_o
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_len(input bit quiet);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Eight times the center minus the eight neighbors, clamped to a byte
  function automatic logic [7:0] chan_response(input lef_pkg::column_t l,
                                               input lef_pkg::column_t c,
                                               input lef_pkg::column_t r,
                                               input int unsigned sh);
    lef_pkg::pix_t cells [9];
    int            acc;
    cells = '{l.top, l.mid, l.bot, c.top, c.mid, c.bot, r.top, r.mid, r.bot};
    acc = 9 * int'((c.mid >> sh) & 24'hFF);
    for (int i = 0; i < 9; i++) acc -= int'((cells[i] >> sh) & 24'hFF);
    if (acc <= 0) return 8'd0;
    if (acc >= 255) return 8'd255;
    return acc[7:0];
  endfunction

  // Advance the mirror by one pixel; return 1 when an interior result is due
  function automatic bit filter_pixel(input lef_pkg::pix_t px,
                                      output lef_pkg::result_t res);
    int unsigned      w;
    int unsigned      h;
    lef_pkg::column_t cur;
    bit               hit;
    w = (width_reg < 3) ? 3
      : ((width_reg > lef_pkg::MaxWidth) ? lef_pkg::MaxWidth : width_reg);
    h = (height_reg < 3) ? 3 : height_reg;
    cur.top = upper_line[col_pos];
    cur.mid = middle_line[col_pos];
    cur.bot = px;
    upper_line[col_pos]  = cur.mid;
    middle_line[col_pos] = px;
    hit = (col_pos >= 2) && (row_pos >= 2);
    res = '0;
    if (hit) begin
      res.red        = chan_response(left_col, center_col, cur, 16);
      res.green      = chan_response(left_col, center_col, cur, 8);
      res.blue       = chan_response(left_col, center_col, cur, 0);
      res.row_done   = (col_pos >= w - 1);
      res.frame_done = res.row_done && (row_pos >= h - 1);
    end
    left_col   = center_col;
    center_col = cur;
    if (col_pos >= w - 1) begin
      col_pos = 0;
      row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    return hit;
  endfunction

  task automatic flag(input string what, input int want, input int got);
    errors++;
    $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
  endtask

  task automatic check_edge(input lef_pkg::result_t got);
    lef_pkg::result_t want;
    if (pending_edges.size() == 0) begin
      errors++;
      $display("%0t: result with none expected: rgb %0d %0d %0d row %0b frame %0b",
               $time, got.red, got.green, got.blue, got.row_done, got.frame_done);
    end else begin
      want = pending_edges.pop_front();
      if (got.red !== want.red) flag("edge_red", want.red, got.red);
      if (got.green !== want.green) flag("edge_green", want.green, got.green);
      if (got.blue !== want.blue) flag("edge_blue", want.blue, got.blue);
      if (got.row_done !== want.row_done) flag("row_done", want.row_done, got.row_done);
      if (got.frame_done !== want.frame_done)
        flag("frame_done", want.frame_done, got.frame_done);
    end
  endtask

  // Track register writes and pixel transfers, check result transfers
  always @(posedge clk_i) begin : scoreboard
    step_t            note;
    lef_pkg::result_t want;
    bit               hit;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_index_i == lef_pkg::REG_FRAME_WIDTH)
          width_reg = cfg_data_i[lef_pkg::WidthW-1:0];
        else height_reg = cfg_data_i[lef_pkg::RowW-1:0];
        col_pos = 0;
        row_pos = 0;
      end
      if (in_valid_i && in_ready_o) begin
        note = stated_results.pop_front();
        hit  = filter_pixel(lef_pkg::pix_t'{pixel_red_i, pixel_green_i, pixel_blue_i},
                            want);
        if (note.given) pending_edges.push_back(note.res);
        else if (hit) pending_edges.push_back(want);
      end
      if (out_valid_o && out_ready_i)
        check_edge(lef_pkg::result_t'{edge_red_o, edge_green_o, edge_blue_o,
                                      row_done_o, frame_done_o});
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int unsigned gap;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (backpressure_req) begin
        gap = HoldCycles;
        backpressure_req = 1'b0;
      end else begin
        gap = idle_len(quiet_recv);
      end
      if (gap == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic index, input logic [lef_pkg::CfgW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Hold valid and payload until the transfer; called and left at a falling edge
  task automatic offer_pixel(input lef_pkg::pix_t px, input bit given,
                             input lef_pkg::result_t res);
    int unsigned gap;
    gap = idle_len(quiet_send);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    stated_results.push_back(step_t'{px, given, res});
    in_valid_i    <= 1'b1;
    pixel_red_i   <= px.red;
    pixel_green_i <= px.green;
    pixel_blue_i  <= px.blue;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Wait out every expected result, then the pipeline behind border pixels
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_edges.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  function automatic logic [7:0] drift(input logic [7:0] v);
    int x;
    x = int'(v) + int'($urandom_range(0, 12)) - 6;
    return (x < 0) ? 8'd0 : ((x > 255) ? 8'd255 : x[7:0]);
  endfunction

  function automatic lef_pkg::pix_t make_pixel(input pix_style_e style,
                                               input lef_pkg::pix_t base);
    logic [31:0]   raw;
    lef_pkg::pix_t p;
    raw = $urandom;
    case (style)
      PIX_SMOOTH: p = '{drift(base.red), drift(base.green), drift(base.blue)};
      PIX_RAILS:  p = '{raw[0] ? 8'hFF : 8'h00, raw[1] ? 8'hFF : 8'h00,
                        raw[2] ? 8'hFF : 8'h00};
      default:    p = raw[23:0];
    endcase
    return p;
  endfunction

  task automatic run_phase(input int unsigned wdata, input int unsigned hdata,
                           input int unsigned count, input pix_style_e style);
    lef_pkg::pix_t base;
    logic [31:0]   raw;
    raw  = $urandom;
    base = raw[23:0];
    write_reg(lef_pkg::REG_FRAME_WIDTH, lef_pkg::CfgW'(wdata));
    write_reg(lef_pkg::REG_FRAME_HEIGHT, lef_pkg::CfgW'(hdata));
    repeat (count) offer_pixel(make_pixel(style, base), 1'b0, NoEdge);
    drain_results();
  endtask

  initial begin : stimulus
    int unsigned random_items;
    int unsigned r;
    int unsigned wval;
    int unsigned hval;
    int unsigned n;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = lef_pkg::REG_FRAME_WIDTH;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    pixel_red_i   = '0;
    pixel_green_i = '0;
    pixel_blue_i  = '0;
    left_col      = '0;
    center_col    = '0;
    col_pos       = 0;
    row_pos       = 0;
    width_reg     = lef_pkg::ResetWidth;
    height_reg    = lef_pkg::ResetHeight;
    random_items  = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Smallest frame, results stated by hand
    write_reg(lef_pkg::REG_FRAME_WIDTH, lef_pkg::CfgW'(3));
    write_reg(lef_pkg::REG_FRAME_HEIGHT, lef_pkg::CfgW'(3));
    foreach (directed[i]) offer_pixel(directed[i].px, directed[i].given, directed[i].res);
    drain_results();

    // Width beyond the line store clamps to the full line; first row only
    run_phase(32'hFFFF, 3, WidePixels, PIX_SMOOTH);
    // Tallest frame, cut short by the next write
    run_phase(3, 32'hFFFF, 15, PIX_NOISE);
    run_phase(2, 0, 20, PIX_RAILS);

    // Stall the result side while the sender keeps pushing
    quiet_send       = 1'b1;
    backpressure_req = 1'b1;
    run_phase(6, 5, 150, PIX_NOISE);
    quiet_send = 1'b0;

    // Random frame shapes, partial frames now and then
    while (random_items < RandomPixels) begin
      r    = $urandom_range(0, 99);
      wval = (r < 6) ? $urandom_range(0, 2)
           : ((r < 80) ? $urandom_range(3, 12) : $urandom_range(13, 40));
      r    = $urandom_range(0, 99);
      hval = (r < 6) ? $urandom_range(0, 2) : $urandom_range(3, 7);
      n    = $urandom_range(1, 3) * ((wval < 3) ? 3 : wval) * ((hval < 3) ? 3 : hval);
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      quiet_send = ($urandom_range(0, 5) == 0);
      quiet_recv = ($urandom_range(0, 5) == 0);
      run_phase(($urandom_range(0, 15) << 12) | wval, hval, n,
                pix_style_e'($urandom_range(0, 2)));
      random_items += n;
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
